// ----- hdl/pmsog_pkg.sv -----
// Shared types and constants for the pattern matcher with star, optional and gap.
package pmsog_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_WORD   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_LIT  = 2'd0,
    K_GAP  = 2'd1,
    K_STAR = 2'd2,
    K_OPT  = 2'd3
  } kind_t;

  localparam logic [7:0] SYM_GAP  = 8'h7E;
  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_OPT  = 8'h3F;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic [7:0] sym;
  } pat_cmd_t;

endpackage

// ----- hdl/pmsog_pat.sv -----
// Pattern store with per-position kind decode, length and overflow tracking.
module pmsog_pat #(
  parameter int MAX_PATTERN = 32,
  parameter int PW = $clog2(MAX_PATTERN + 1),
  parameter int AW = $clog2(MAX_PATTERN)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pmsog_pkg::pat_cmd_t cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     kind_addr,
  output logic [7:0]        rd_sym,
  output pmsog_pkg::kind_t  kind,
  output logic [PW-1:0]     len,
  output logic              ovf
);
  import pmsog_pkg::*;

  logic [7:0]    mem [MAX_PATTERN];
  logic [7:0]    rd_sym_r;
  kind_t         kind_r [MAX_PATTERN];
  logic [PW-1:0] len_r;
  logic          ovf_r;
  logic          last_gap_r;
  logic          room;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] prev_idx;

  assign room     = (len_r < PW'(MAX_PATTERN));
  assign wr_idx   = len_r[AW-1:0];
  assign prev_idx = wr_idx - AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.append && room) begin
      mem[wr_idx] <= cmd.sym;
    end
    rd_sym_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      ovf_r      <= 1'b0;
      last_gap_r <= 1'b0;
    end else if (cmd.clear) begin
      len_r      <= '0;
      ovf_r      <= 1'b0;
      last_gap_r <= 1'b0;
    end else if (cmd.append) begin
      if (room) begin
        kind_r[wr_idx] <= (cmd.sym == SYM_GAP) ? K_GAP : K_LIT;
        if (len_r != '0 && !last_gap_r) begin
          if (cmd.sym == SYM_STAR) begin
            kind_r[prev_idx] <= K_STAR;
          end else if (cmd.sym == SYM_OPT) begin
            kind_r[prev_idx] <= K_OPT;
          end
        end
        last_gap_r <= (cmd.sym == SYM_GAP);
        len_r      <= len_r + PW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign rd_sym = rd_sym_r;
  assign kind   = kind_r[kind_addr];
  assign len    = len_r;
  assign ovf    = ovf_r;

endmodule

// ----- hdl/pattern_match_star_optional_gap.sv -----
// Top level of the whole-word matcher with star, optional and bounded gap.
//
//   port group  | direction | contents
//   in_         | request   | in_operation, in_symbol under in_valid / in_stall
//   out_        | result    | out_matched under out_valid / out_stall
//   cfg_        | write     | cfg_wr_data (max gap) under cfg_wr_en
//
// Clear and append requests are taken straight from the idle state. A word byte
// or end of word walks the pattern with one position update unit that visits the
// positions one per cycle, and the input stalls until the block is idle again.
// Reset is synchronous and active low and leaves an empty pattern, a gap limit of
// zero and a fresh word. A finished result waits while an earlier one is stalled.
module pattern_match_star_optional_gap #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import pmsog_pkg::*;

  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam int AW = $clog2(MAX_PATTERN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t             state_r;
  logic [PW-1:0]      p_r;
  logic               eow_r;
  logic [7:0]         sym_r;
  logic [7:0]         max_gap_r;
  logic               match_r;
  logic               out_valid_r;
  logic               out_matched_r;
  logic [MAX_PATTERN:0] cur_act_r;
  logic [MAX_PATTERN:0] nxt_act_r;
  logic [7:0]         cur_cnt_r [MAX_PATTERN];
  logic [7:0]         nxt_cnt_r [MAX_PATTERN];

  pat_cmd_t           cmd;
  logic [PW-1:0]      p1;
  logic [PW-1:0]      p2;
  logic               p1_slot;
  logic               p2_slot;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         pat_sym;
  kind_t              pat_kind;
  logic [PW-1:0]      pat_len;
  logic               pat_ovf;
  logic               accept;
  logic [7:0]         cnt;
  logic               sym_eq;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_stall   = (state_r != S_IDLE);
  assign cmd.clear  = accept && (op_t'(in_operation) == OP_CLEAR);
  assign cmd.append = accept && (op_t'(in_operation) == OP_APPEND);
  assign cmd.sym    = in_symbol;
  assign p1         = p_r + PW'(1);
  assign p2         = p_r + PW'(2);
  assign p1_slot    = (p1 < PW'(MAX_PATTERN));
  assign p2_slot    = (p2 < PW'(MAX_PATTERN));
  assign rd_addr    = (state_r == S_IDLE) ? '0 : p1[AW-1:0];
  assign cnt        = cur_cnt_r[p_r[AW-1:0]];
  assign sym_eq     = (pat_sym == sym_r);

  pmsog_pat #(
    .MAX_PATTERN(MAX_PATTERN),
    .PW(PW),
    .AW(AW)
  ) u_pat (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .kind_addr(p_r[AW-1:0]),
    .rd_sym   (pat_sym),
    .kind     (pat_kind),
    .len      (pat_len),
    .ovf      (pat_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_r         <= '0;
      eow_r       <= 1'b0;
      max_gap_r   <= '0;
      out_valid_r <= 1'b0;
      cur_act_r   <= (MAX_PATTERN+1)'(1);
      nxt_act_r   <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        cur_cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        max_gap_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (op_t'(in_operation))
              OP_CLEAR: begin
                cur_act_r <= (MAX_PATTERN+1)'(1);
                for (int i = 0; i < MAX_PATTERN; i++) begin
                  cur_cnt_r[i] <= '0;
                end
              end
              OP_APPEND: begin
              end
              default: begin
                eow_r     <= (op_t'(in_operation) == OP_END);
                sym_r     <= in_symbol;
                nxt_act_r <= '0;
                p_r       <= '0;
                state_r   <= S_WALK;
              end
            endcase
          end
        end
        S_WALK: begin
          if (p_r == pat_len) begin
            if (eow_r) begin
              match_r   <= cur_act_r[p_r] && !pat_ovf;
              cur_act_r <= (MAX_PATTERN+1)'(1);
              for (int i = 0; i < MAX_PATTERN; i++) begin
                cur_cnt_r[i] <= '0;
              end
              state_r <= S_FIN;
            end else begin
              cur_act_r <= nxt_act_r;
              cur_cnt_r <= nxt_cnt_r;
              state_r   <= S_IDLE;
            end
          end else begin
            if (cur_act_r[p_r]) begin
              case (pat_kind)
                K_GAP: begin
                  cur_act_r[p1] <= 1'b1;
                  if (p1_slot) begin
                    cur_cnt_r[p1[AW-1:0]] <= '0;
                  end
                end
                K_STAR, K_OPT: begin
                  cur_act_r[p2] <= 1'b1;
                  if (p2_slot) begin
                    cur_cnt_r[p2[AW-1:0]] <= '0;
                  end
                end
                default: begin
                end
              endcase
              if (!eow_r) begin
                case (pat_kind)
                  K_GAP: begin
                    if (cnt < max_gap_r) begin
                      if (!nxt_act_r[p_r]) begin
                        nxt_cnt_r[p_r[AW-1:0]] <= cnt + 8'd1;
                      end
                      nxt_act_r[p_r] <= 1'b1;
                    end
                  end
                  K_STAR: begin
                    if (sym_eq) begin
                      nxt_act_r[p_r] <= 1'b1;
                      nxt_cnt_r[p_r[AW-1:0]] <= '0;
                    end
                  end
                  K_OPT: begin
                    if (sym_eq) begin
                      nxt_act_r[p2] <= 1'b1;
                      if (p2_slot) begin
                        nxt_cnt_r[p2[AW-1:0]] <= '0;
                      end
                    end
                  end
                  default: begin
                    if (sym_eq) begin
                      nxt_act_r[p1] <= 1'b1;
                      if (p1_slot) begin
                        nxt_cnt_r[p1[AW-1:0]] <= '0;
                      end
                    end
                  end
                endcase
              end
            end
            p_r <= p1;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_matched_r <= match_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (p_r <= pat_len))
    else $error("position pointer ran past the pattern end");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_t'(in_operation) == OP_CLEAR) |=> (pat_len == '0 && !pat_ovf))
    else $error("clear did not empty the pattern");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    pat_ovf |-> (pat_len == PW'(MAX_PATTERN)))
    else $error("overflow flagged with room left");

  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op_t'(in_operation) == OP_WORD || op_t'(in_operation) == OP_END))
      |=> (state_r == S_WALK && p_r == '0))
    else $error("word request did not start a walk at position zero");
`endif

endmodule

// ----- bench/tb_pattern_match_star_optional_gap.sv -----
// Self-checking testbench for the pattern matcher with star, optional and bounded gap.
`timescale 1ns / 1ps

module tb_pattern_match_star_optional_gap;
  import pmsog_pkg::*;

  localparam int PAT_MAX = 32;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_symbol;
  logic       out_valid;
  logic       out_stall;
  logic       out_matched;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  logic [7:0]          gap_limit;
  logic [7:0]          pat_bytes[PAT_MAX];
  int                  pat_len;
  logic [PAT_MAX:0]    reached;
  logic [7:0]          skips[PAT_MAX+1];
  logic                pat_overflow;

  logic                match_queue[$];
  int                  errors;
  int                  matches_seen;
  int                  ones_seen;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_cycles;

  pattern_match_star_optional_gap i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_symbol    (in_symbol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #200ms;
    $display("tb_pattern_match_star_optional_gap failed");
    $finish;
  end

  function automatic kind_t kind_at(int p);
    if (pat_bytes[p] == SYM_GAP) return K_GAP;
    if (p + 1 < pat_len) begin
      if (pat_bytes[p+1] == SYM_STAR) return K_STAR;
      if (pat_bytes[p+1] == SYM_OPT) return K_OPT;
    end
    return K_LIT;
  endfunction

  task automatic close_positions(output logic [PAT_MAX:0] act, output logic [7:0] cnt[PAT_MAX+1]);
    kind_t k;
    int t;
    act = reached;
    for (int p = 0; p <= PAT_MAX; p++) cnt[p] = skips[p];
    for (int p = 0; p < pat_len; p++) begin
      if (act[p]) begin
        k = kind_at(p);
        if (k != K_LIT) begin
          t = (k == K_GAP) ? p + 1 : p + 2;
          act[t] = 1'b1;
          cnt[t] = 8'd0;
        end
      end
    end
  endtask

  task automatic restart_word();
    reached = '0;
    reached[0] = 1'b1;
    for (int p = 0; p <= PAT_MAX; p++) skips[p] = 8'd0;
  endtask

  task automatic enter_position(int t, logic [7:0] c);
    if (!reached[t] || c < skips[t]) skips[t] = c;
    reached[t] = 1'b1;
  endtask

  task automatic predict_request(op_t op, logic [7:0] sym);
    logic [PAT_MAX:0] act;
    logic [7:0] cnt[PAT_MAX+1];
    kind_t k;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        pat_overflow = 1'b0;
        restart_word();
      end
      OP_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = sym;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
      end
      OP_WORD: begin
        close_positions(act, cnt);
        reached = '0;
        for (int p = 0; p <= PAT_MAX; p++) skips[p] = 8'd0;
        for (int p = 0; p < pat_len; p++) begin
          if (act[p]) begin
            k = kind_at(p);
            if (k == K_GAP) begin
              if (cnt[p] < gap_limit) enter_position(p, cnt[p] + 8'd1);
            end else if (pat_bytes[p] == sym) begin
              if (k == K_STAR) enter_position(p, 8'd0);
              else if (k == K_OPT) enter_position(p + 2, 8'd0);
              else enter_position(p + 1, 8'd0);
            end
          end
        end
      end
      default: begin
        close_positions(act, cnt);
        match_queue.push_back(act[pat_len] && !pat_overflow);
        restart_word();
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic send_request(op_t op, logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
    predict_request(op, sym);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      matches_seen++;
      if (match_queue.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        if (out_matched !== match_queue[0])
          report_mismatch($sformatf("matched %b, expected %b", out_matched, match_queue[0]));
        if (match_queue[0]) ones_seen++;
        void'(match_queue.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (match_queue.size() != 0) @(negedge clk);
    repeat (2 * PAT_MAX + 20) @(negedge clk);
  endtask

  task automatic set_gap(logic [7:0] g);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gap_limit = g;
  endtask

  task automatic load_pattern(string s);
    send_request(OP_CLEAR, 8'($urandom));
    for (int i = 0; i < s.len(); i++) send_request(OP_APPEND, s[i]);
  endtask

  task automatic send_word(string s);
    for (int i = 0; i < s.len(); i++) send_request(OP_WORD, s[i]);
    send_request(OP_END, 8'($urandom));
  endtask

  task automatic test_directed();
    set_gap(8'd2);
    send_word("");
    send_word("a");
    load_pattern("ab*c?~d");
    send_word("ad");
    send_word("abbcxxd");
    send_word("abcxxxd");
    load_pattern("a*");
    send_word("aaa");
    load_pattern("~*");
    send_word("*");
    send_request(OP_APPEND, 8'h00);
    send_request(OP_WORD, 8'hFF);
    send_request(OP_END, 8'h00);
  endtask

  task automatic test_overflow();
    send_request(OP_CLEAR, 8'h00);
    for (int i = 0; i < PAT_MAX + 1; i++) send_request(OP_APPEND, "~");
    send_word("x");
    send_request(OP_CLEAR, 8'hFF);
    for (int i = 0; i < PAT_MAX; i++) send_request(OP_APPEND, 8'hFF);
    for (int i = 0; i < PAT_MAX; i++) send_request(OP_WORD, 8'hFF);
    send_request(OP_END, 8'h00);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(5))
      0: return SYM_GAP;
      1: return SYM_STAR;
      2: return SYM_OPT;
      3: return 8'($urandom);
      default: return 8'("a" + $urandom_range(2));
    endcase
  endfunction

  task automatic test_random(int items);
    int sent;
    int n;
    logic [7:0] sym;
    sent = 0;
    while (sent < items) begin
      send_request(OP_CLEAR, 8'($urandom));
      n = ($urandom_range(15) == 0) ? $urandom_range(PAT_MAX + 2) : $urandom_range(8);
      for (int i = 0; i < n; i++) send_request(OP_APPEND, pick_symbol());
      sent += n + 1;
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(10);
        for (int i = 0; i < n; i++) begin
          sym = ($urandom_range(3) == 0) ? 8'($urandom) : 8'("a" + $urandom_range(2));
          send_request(OP_WORD, sym);
          if ($urandom_range(30) == 0) send_request(OP_APPEND, pick_symbol());
        end
        send_request(OP_END, 8'($urandom));
        sent += n + 1;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    load_pattern("a~b");
    repeat (12) send_word("axb");
    drain();
  endtask

  initial begin
    errors = 0;
    matches_seen = 0;
    ones_seen = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_CLEAR;
    in_symbol = 8'h00;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    gap_limit = 8'd0;
    pat_len = 0;
    pat_overflow = 1'b0;
    for (int p = 0; p < PAT_MAX; p++) pat_bytes[p] = 8'h00;
    restart_word();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_overflow();
    test_backpressure();
    send_idle_pct = 15;
    recv_idle_pct = 80;
    set_gap(8'd0);
    test_random(210);
    send_idle_pct = 80;
    recv_idle_pct = 15;
    set_gap(8'd255);
    test_random(210);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_gap(8'd3);
    test_random(220);
    drain();

    $display("Checked %0d match results, %0d of them positive.", matches_seen, ones_seen);
    $display("Covered gap limits 0, 2, 3 and 255, overflow, and a long result hold-off.");
    if (errors == 0) begin
      $display("tb_pattern_match_star_optional_gap passed");
    end else begin
      $display("tb_pattern_match_star_optional_gap failed");
    end
    $finish;
  end

endmodule
